>>> rtl/core/ecpm_pkg.sv
// Package for the elliptic-curve point multiplier.
// Holds the sequencer state codes, the arithmetic unit command type and register indexes.
// No dependencies.
`default_nettype none

package ecpm_pkg;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_CUBIC  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_SQUARE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_LINEAR = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIELD_PRIME = 2'd3;

   localparam int CUBIC_RESET = 1;
   localparam int PRIME_RESET = 65521;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } cmd_type;

   typedef enum logic [22:0] {
      ST_IDLE     = 23'h000001,
      ST_WAIT     = 23'h000002,
      ST_RED_PY   = 23'h000004,
      ST_RED_A    = 23'h000008,
      ST_RED_B    = 23'h000010,
      ST_RED_C    = 23'h000020,
      ST_PREP     = 23'h000040,
      ST_INV_TEST = 23'h000080,
      ST_INV_Q    = 23'h000100,
      ST_INV_T    = 23'h000200,
      ST_INVA     = 23'h000400,
      ST_LOOP     = 23'h000800,
      ST_TAN1     = 23'h001000,
      ST_TAN2     = 23'h002000,
      ST_TAN3     = 23'h004000,
      ST_TAN4     = 23'h008000,
      ST_TAN5     = 23'h010000,
      ST_CHORD    = 23'h020000,
      ST_SLOPE    = 23'h040000,
      ST_XR1      = 23'h080000,
      ST_XR2      = 23'h100000,
      ST_XR3      = 23'h200000,
      ST_DONE     = 23'h400000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/ecpm_if.sv
// Handshake interfaces for the point multiplier's request and response words.
// Depends on nothing; widths come from parameters.
`default_nettype none

interface ecpm_req_if #(
   parameter int FIELD_BITS  = 16,
   parameter int SCALAR_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [FIELD_BITS-1:0]  base_x;
   logic [FIELD_BITS-1:0]  base_y;
   logic [SCALAR_BITS-1:0] scalar;

   modport source (output valid, base_x, base_y, scalar, input ready);
   modport sink   (input valid, base_x, base_y, scalar, output ready);
endinterface

interface ecpm_rsp_if #(
   parameter int FIELD_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] result_x;
   logic [FIELD_BITS-1:0] result_y;
   logic                  at_infinity;

   modport source (output valid, result_x, result_y, at_infinity, input ready);
   modport sink   (input valid, result_x, result_y, at_infinity, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ecpm_arith.sv
// Shared bit-serial arithmetic unit: modular multiply and integer divide.
// One bit per cycle. Uses ecpm_pkg.
`default_nettype none

module ecpm_arith
   import ecpm_pkg::*;
#(
   parameter int FIELD_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic [FIELD_BITS-1:0] opx,
   input  wire logic [FIELD_BITS-1:0] opy,
   input  wire logic [FIELD_BITS-1:0] modulus,
   output logic                       done,
   output logic [FIELD_BITS-1:0]      quo,
   output logic [FIELD_BITS-1:0]      rem
);

   localparam int CNT_BITS = $clog2(FIELD_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   op_type                op_ff, op_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [FIELD_BITS-1:0] x_ff, x_in;
   logic [FIELD_BITS-1:0] y_ff, y_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;

   logic                  bit_top;
   logic [FIELD_BITS:0]   dbl, dbl_red, sum;
   logic [FIELD_BITS:0]   shr;

   always_comb begin
      bit_top = x_ff[FIELD_BITS-1];
      // Multiply: acc = 2*acc + bit*y, kept below the modulus.
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum     = dbl_red + (bit_top ? {1'b0, y_ff} : '0);
      if (sum >= {1'b0, modulus}) begin
         sum = sum - {1'b0, modulus};
      end
      // Divide: restoring step, quotient bits enter x from the bottom.
      shr = {acc_ff, bit_top};

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = CNT_BITS'(FIELD_BITS);
         x_in    = opx;
         y_in    = opy;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == OP_MUL) begin
            acc_in = sum[FIELD_BITS-1:0];
            x_in   = {x_ff[FIELD_BITS-2:0], 1'b0};
         end else if (shr >= {1'b0, y_ff}) begin
            acc_in = FIELD_BITS'(shr - {1'b0, y_ff});
            x_in   = {x_ff[FIELD_BITS-2:0], 1'b1};
         end else begin
            acc_in = shr[FIELD_BITS-1:0];
            x_in   = {x_ff[FIELD_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign quo  = x_ff;
   assign rem  = acc_ff;

endmodule

`default_nettype wire

>>> rtl/core/ec_point_scalar_multiply.sv
// Elliptic-curve scalar multiplier, affine coordinates over the integers modulo field_prime.
// A request word (base_x, base_y, scalar) yields one response word holding scalar times the
// base point, formed by repeated point addition; scalars of 0 and 1 return the base point.
// Every operation runs through one bit-serial modular multiply/divide unit. Setup takes
// five divides plus one inversion. A chord addition takes four multiplies and a
// tangent addition eight, each plus one extended-Euclid inversion of up to about
// 1.5*FIELD_BITS steps, each step a divide and a multiply. A step into or out of
// infinity uses no arithmetic operation. There are (scalar-1) such steps per word.
// The block takes one word at a time and is not ready while busy. Uses ecpm_pkg,
// ecpm_if and ecpm_arith.
`default_nettype none

module ec_point_scalar_multiply
   import ecpm_pkg::*;
#(
   parameter int FIELD_BITS  = 16,
   parameter int SCALAR_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   ecpm_req_if.sink                     req_chan,
   ecpm_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [FIELD_BITS-1:0]   csr_wdata
);

   typedef logic [FIELD_BITS-1:0] fe_type;

   state_type state_ff, state_in, after_ff, after_in, ret_ff, ret_in;
   fe_type cfa_ff, cfb_ff, cfc_ff, prime_ff;
   fe_type px_ff, px_in, py_ff, py_in, qx_ff, qx_in, qy_ff, qy_in;
   fe_type a_ff, a_in, b_ff, b_in, c_ff, c_in, a3_ff, a3_in, b2_ff, b2_in;
   fe_type inva_ff, inva_in, m_ff, m_in, s_ff, s_in, inv_ff, inv_in;
   fe_type r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   fe_type ox_ff, ox_in, oy_ff, oy_in;
   logic   qinf_ff, qinf_in, oinf_ff, oinf_in;
   logic [SCALAR_BITS-1:0] n_ff, n_in;

   cmd_type cmd;
   fe_type  opx, opy, alu_quo, alu_rem, inv2, rx;
   logic    alu_done;

   function automatic fe_type mod_add(fe_type x, fe_type y, fe_type p);
      logic [FIELD_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, p}) begin
         s = s - {1'b0, p};
      end
      return s[FIELD_BITS-1:0];
   endfunction

   function automatic fe_type mod_sub(fe_type x, fe_type y, fe_type p);
      fe_type d;
      d = x - y;
      if (x < y) begin
         d = d + p;
      end
      return d;
   endfunction

   ecpm_arith #(.FIELD_BITS(FIELD_BITS)) u_arith (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .opx     (opx),
      .opy     (opy),
      .modulus (prime_ff),
      .done    (alu_done),
      .quo     (alu_quo),
      .rem     (alu_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfa_ff   <= FIELD_BITS'(CUBIC_RESET);
         cfb_ff   <= '0;
         cfc_ff   <= '0;
         prime_ff <= FIELD_BITS'(PRIME_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_CUBIC:  cfa_ff   <= csr_wdata;
            CSR_COEF_SQUARE: cfb_ff   <= csr_wdata;
            CSR_COEF_LINEAR: cfc_ff   <= csr_wdata;
            CSR_FIELD_PRIME: prime_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The inverse of two exists only for an odd modulus, where it is (p+1)/2.
   assign inv2 = prime_ff[0] ? FIELD_BITS'(({1'b0, prime_ff} + 1'b1) >> 1) : '0;
   assign rx   = mod_sub(mod_sub(alu_rem, px_ff, prime_ff), qx_ff, prime_ff);

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      ret_in   = ret_ff;
      px_in = px_ff;  py_in = py_ff;  qx_in = qx_ff;  qy_in = qy_ff;
      a_in  = a_ff;   b_in  = b_ff;   c_in  = c_ff;   a3_in = a3_ff;  b2_in = b2_ff;
      inva_in = inva_ff;  m_in = m_ff;  s_in = s_ff;  inv_in = inv_ff;
      r0_in = r0_ff;  r1_in = r1_ff;  t0_in = t0_ff;  t1_in = t1_ff;
      ox_in = ox_ff;  oy_in = oy_ff;  oinf_in = oinf_ff;
      qinf_in = qinf_ff;  n_in = n_ff;
      cmd.start = 1'b0;
      cmd.op    = OP_MUL;
      opx = '0;
      opy = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               n_in  = req_chan.scalar;
               py_in = req_chan.base_y;
               if (prime_ff < FIELD_BITS'(2)) begin
                  ox_in    = req_chan.base_x;
                  oy_in    = req_chan.base_y;
                  oinf_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  cmd = '{start: 1'b1, op: OP_DIV};
                  opx = req_chan.base_x;
                  opy = prime_ff;
                  after_in = ST_RED_PY;
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (alu_done) begin
               state_in = after_ff;
            end
         end
         ST_RED_PY: begin
            px_in = alu_rem;
            cmd = '{start: 1'b1, op: OP_DIV};
            opx = py_ff;
            opy = prime_ff;
            after_in = ST_RED_A;
            state_in = ST_WAIT;
         end
         ST_RED_A: begin
            py_in = alu_rem;
            cmd = '{start: 1'b1, op: OP_DIV};
            opx = cfa_ff;
            opy = prime_ff;
            after_in = ST_RED_B;
            state_in = ST_WAIT;
         end
         ST_RED_B: begin
            a_in = alu_rem;
            cmd = '{start: 1'b1, op: OP_DIV};
            opx = cfb_ff;
            opy = prime_ff;
            after_in = ST_RED_C;
            state_in = ST_WAIT;
         end
         ST_RED_C: begin
            b_in = alu_rem;
            cmd = '{start: 1'b1, op: OP_DIV};
            opx = cfc_ff;
            opy = prime_ff;
            after_in = ST_PREP;
            state_in = ST_WAIT;
         end
         ST_PREP: begin
            c_in  = alu_rem;
            a3_in = mod_add(mod_add(a_ff, a_ff, prime_ff), a_ff, prime_ff);
            b2_in = mod_add(b_ff, b_ff, prime_ff);
            qx_in = px_ff;
            qy_in = py_ff;
            qinf_in = 1'b0;
            r0_in = prime_ff;
            r1_in = a_ff;
            t0_in = '0;
            t1_in = FIELD_BITS'(1);
            ret_in   = ST_INVA;
            state_in = ST_INV_TEST;
         end
         // Extended Euclid with the cofactor kept reduced modulo p.
         ST_INV_TEST: begin
            if (r1_ff == '0) begin
               inv_in   = (r0_ff == FIELD_BITS'(1)) ? t0_ff : '0;
               state_in = ret_ff;
            end else begin
               cmd = '{start: 1'b1, op: OP_DIV};
               opx = r0_ff;
               opy = r1_ff;
               after_in = ST_INV_Q;
               state_in = ST_WAIT;
            end
         end
         ST_INV_Q: begin
            s_in = alu_rem;
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = alu_quo;
            opy = t1_ff;
            after_in = ST_INV_T;
            state_in = ST_WAIT;
         end
         ST_INV_T: begin
            r0_in = r1_ff;
            r1_in = s_ff;
            t0_in = t1_ff;
            t1_in = mod_sub(t0_ff, alu_rem, prime_ff);
            state_in = ST_INV_TEST;
         end
         ST_INVA: begin
            inva_in  = inv_ff;
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (n_ff <= SCALAR_BITS'(1)) begin
               ox_in    = qx_ff;
               oy_in    = qy_ff;
               oinf_in  = qinf_ff;
               state_in = ST_DONE;
            end else begin
               n_in = n_ff - 1'b1;
               if (qinf_ff) begin
                  qx_in = px_ff;
                  qy_in = py_ff;
                  qinf_in = 1'b0;
               end else if (px_ff == qx_ff && (py_ff != qy_ff || py_ff == '0)) begin
                  qx_in = '0;
                  qy_in = '0;
                  qinf_in = 1'b1;
               end else if (px_ff == qx_ff) begin
                  cmd = '{start: 1'b1, op: OP_MUL};
                  opx = px_ff;
                  opy = px_ff;
                  after_in = ST_TAN1;
                  state_in = ST_WAIT;
               end else begin
                  r0_in = prime_ff;
                  r1_in = mod_sub(qx_ff, px_ff, prime_ff);
                  t0_in = '0;
                  t1_in = FIELD_BITS'(1);
                  ret_in   = ST_CHORD;
                  state_in = ST_INV_TEST;
               end
            end
         end
         ST_TAN1: begin
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = alu_rem;
            opy = a3_ff;
            after_in = ST_TAN2;
            state_in = ST_WAIT;
         end
         ST_TAN2: begin
            s_in = alu_rem;
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = px_ff;
            opy = b2_ff;
            after_in = ST_TAN3;
            state_in = ST_WAIT;
         end
         ST_TAN3: begin
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = mod_add(mod_add(s_ff, alu_rem, prime_ff), c_ff, prime_ff);
            opy = inv2;
            after_in = ST_TAN4;
            state_in = ST_WAIT;
         end
         ST_TAN4: begin
            m_in  = alu_rem;
            r0_in = prime_ff;
            r1_in = py_ff;
            t0_in = '0;
            t1_in = FIELD_BITS'(1);
            ret_in   = ST_TAN5;
            state_in = ST_INV_TEST;
         end
         ST_TAN5: begin
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = m_ff;
            opy = inv_ff;
            after_in = ST_SLOPE;
            state_in = ST_WAIT;
         end
         ST_CHORD: begin
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = mod_sub(qy_ff, py_ff, prime_ff);
            opy = inv_ff;
            after_in = ST_SLOPE;
            state_in = ST_WAIT;
         end
         ST_SLOPE: begin
            m_in = alu_rem;
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = alu_rem;
            opy = alu_rem;
            after_in = ST_XR1;
            state_in = ST_WAIT;
         end
         ST_XR1: begin
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = mod_sub(alu_rem, b_ff, prime_ff);
            opy = inva_ff;
            after_in = ST_XR2;
            state_in = ST_WAIT;
         end
         ST_XR2: begin
            s_in = rx;
            cmd = '{start: 1'b1, op: OP_MUL};
            opx = mod_sub(px_ff, rx, prime_ff);
            opy = m_ff;
            after_in = ST_XR3;
            state_in = ST_WAIT;
         end
         ST_XR3: begin
            qx_in = s_ff;
            qy_in = mod_sub(alu_rem, py_ff, prime_ff);
            state_in = ST_LOOP;
         end
         ST_DONE: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      after_ff <= after_in;
      ret_ff   <= ret_in;
      px_ff <= px_in;  py_ff <= py_in;  qx_ff <= qx_in;  qy_ff <= qy_in;
      a_ff  <= a_in;   b_ff  <= b_in;   c_ff  <= c_in;   a3_ff <= a3_in;  b2_ff <= b2_in;
      inva_ff <= inva_in;  m_ff <= m_in;  s_ff <= s_in;  inv_ff <= inv_in;
      r0_ff <= r0_in;  r1_ff <= r1_in;  t0_ff <= t0_in;  t1_ff <= t1_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;  oinf_ff <= oinf_in;
      qinf_ff <= qinf_in;  n_ff <= n_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_DONE);
   assign rsp_chan.result_x    = ox_ff;
   assign rsp_chan.result_y    = oy_ff;
   assign rsp_chan.at_infinity = oinf_ff;

endmodule

`default_nettype wire

>>> tb/sv/ecpm_checker.sv
// Scoreboard for the point multiplier: follows register writes and request words,
// computes each expected response and compares it with what comes back.
// Depends on ecpm_pkg and the handshake interfaces in ecpm_if.
`default_nettype none

module ecpm_checker
   import ecpm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   ecpm_req_if                          req,
   ecpm_rsp_if                          rsp,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [15:0]             csr_wdata,
   output int                           fail_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        inf;
   } point_word;

   logic [15:0] cubic_q, square_q, linear_q, prime_q;
   point_word   pending_points[$];

   function automatic longint mod_inverse(longint v, longint p);
      longint r0, r1, t0, t1, q, rn, tn;
      r0 = p; r1 = v; t0 = 0; t1 = 1;
      while (r1 != 0) begin
         q  = r0 / r1;
         rn = r0 - q * r1;
         tn = t0 - q * t1;
         r0 = r1; r1 = rn;
         t0 = t1; t1 = tn;
      end
      if (r0 != 1) return 0;
      if (t0 < 0) t0 += p;
      return t0 % p;
   endfunction

   function automatic point_word scalar_multiple(logic [15:0] bx, logic [15:0] by,
                                                 logic [15:0] scalar);
      point_word res;
      longint p, px, py, qx, qy, a, b, c, inv_a, inv2, m, rx, ry, num;
      int unsigned n;
      bit q_inf;
      p = prime_q;
      if (p < 2) begin
         res.x = bx; res.y = by; res.inf = 1'b0;
         return res;
      end
      px = bx % p; py = by % p;
      a = cubic_q % p; b = square_q % p; c = linear_q % p;
      inv_a = mod_inverse(a, p);
      inv2  = mod_inverse(2 % p, p);
      qx = px; qy = py; q_inf = 0;
      n = scalar;
      while (n > 1) begin
         if (q_inf) begin
            qx = px; qy = py; q_inf = 0;
         end else if (px == qx && (py != qy || py == 0)) begin
            qx = 0; qy = 0; q_inf = 1;
         end else begin
            if (px == qx) begin
               num = (((3 % p) * a % p) * (px * px % p)) % p;
               num = (num + ((2 % p) * b % p) * px % p) % p;
               num = (num + c) % p;
               m = ((num * inv2) % p) * mod_inverse(py, p) % p;
            end else begin
               m = ((qy + p - py) % p) * mod_inverse((qx + p - px) % p, p) % p;
            end
            rx = ((m * m % p + p - b) % p) * inv_a % p;
            rx = (rx + p - px) % p;
            rx = (rx + p - qx) % p;
            ry = (m * ((px + p - rx) % p) % p + p - py) % p;
            qx = rx; qy = ry;
         end
         n--;
      end
      res.x = qx[15:0]; res.y = qy[15:0]; res.inf = q_inf;
      return res;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      point_word want;
      if (reset) begin
         cubic_q  = 16'(CUBIC_RESET);
         square_q = '0;
         linear_q = '0;
         prime_q  = 16'(PRIME_RESET);
         pending_points.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COEF_CUBIC:  cubic_q  = csr_wdata;
               CSR_COEF_SQUARE: square_q = csr_wdata;
               CSR_COEF_LINEAR: linear_q = csr_wdata;
               CSR_FIELD_PRIME: prime_q  = csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            pending_points.push_back(scalar_multiple(req.base_x, req.base_y, req.scalar));
         if (rsp.valid && rsp.ready) begin
            if (pending_points.size() == 0) begin
               $error("unexpected response word x=%0d y=%0d inf=%0b",
                      rsp.result_x, rsp.result_y, rsp.at_infinity);
               fail_count++;
            end else begin
               want = pending_points.pop_front();
               if (rsp.result_x !== want.x) begin
                  $error("result_x: expected %0d, got %0d", want.x, rsp.result_x);
                  fail_count++;
               end
               if (rsp.result_y !== want.y) begin
                  $error("result_y: expected %0d, got %0d", want.y, rsp.result_y);
                  fail_count++;
               end
               if (rsp.at_infinity !== want.inf) begin
                  $error("at_infinity: expected %0b, got %0b", want.inf, rsp.at_infinity);
                  fail_count++;
               end
            end
         end
      end
      outstanding = pending_points.size();
   end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Top of the point multiplier testbench: clock, reset, register phases, request and
// response traffic with random gaps, watchdog and verdict.
// Depends on ecpm_pkg, ecpm_if, ecpm_checker and the block itself.
`default_nettype none

module tb;
   import ecpm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_COEF_CUBIC;
   logic [15:0]             csr_wdata = '0;
   int fail_count, outstanding;
   int idle_cycles = 0;
   bit no_gaps = 0;

   ecpm_req_if #(.FIELD_BITS(16), .SCALAR_BITS(16)) req_chan ();
   ecpm_rsp_if #(.FIELD_BITS(16)) rsp_chan ();

   ec_point_scalar_multiply #(.FIELD_BITS(16), .SCALAR_BITS(16)) DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ecpm_checker scoreboard (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.base_x = '0;
      req_chan.base_y = '0;
      req_chan.scalar = '0;
      rsp_chan.ready  = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Response side: random stalls before each word, sometimes none at all.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(logic [15:0] bx, logic [15:0] by, logic [15:0] n);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.base_x <= bx;
      req_chan.base_y <= by;
      req_chan.scalar <= n;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_regs(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] p);
      csr_we <= 1'b1;
      csr_index <= CSR_COEF_CUBIC;  csr_wdata <= a; @(negedge clock);
      csr_index <= CSR_COEF_SQUARE; csr_wdata <= b; @(negedge clock);
      csr_index <= CSR_COEF_LINEAR; csr_wdata <= c; @(negedge clock);
      csr_index <= CSR_FIELD_PRIME; csr_wdata <= p; @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Small scalars keep the run short; a few reach further into the repeated addition.
   function automatic logic [15:0] short_scalar();
      return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 18))
                                         : 16'($urandom_range(0, 8));
   endfunction

   task automatic random_words(int count, int p);
      logic [15:0] bx, by;
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) begin
            bx = 16'($urandom); by = 16'($urandom);
         end else begin
            bx = 16'($urandom % p);
            by = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom % p);
         end
         if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
         send_word(bx, by, short_scalar());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: directed extremes, small scalars, y of zero, coordinates above p.
      send_word(16'd0, 16'd0, 16'd0);
      send_word(16'hFFFF, 16'hFFFF, 16'd1);
      send_word(16'd3, 16'd5, 16'd2);
      send_word(16'd3, 16'd0, 16'd2);
      send_word(16'd7, 16'd0, 16'd3);
      send_word(16'd65520, 16'd1, 16'd3);
      send_word(16'd65530, 16'd65534, 16'd4);
      send_word(16'd12, 16'd34, 16'd6);
      send_word(16'd0, 16'd1, 16'd5);
      drain();

      // Small prime with all coefficients in use; orders are short, so infinity recurs.
      write_regs(16'd2, 16'd3, 16'd5, 16'd97);
      send_word(16'd96, 16'd96, 16'd8);
      send_word(16'd10, 16'd0, 16'd3);
      random_words(35, 97);
      drain();

      // Composite modulus at the top of the range, coefficients at their maximum.
      write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_words(20, 65535);
      drain();

      // Cubic coefficient a multiple of the prime, so its inverse is zero.
      write_regs(16'd23, 16'd1, 16'd7, 16'd23);
      random_words(20, 23);
      drain();

      // Smallest odd prime.
      write_regs(16'd1, 16'd2, 16'd1, 16'd3);
      random_words(15, 3);
      drain();

      // Moduli below two do no arithmetic, so full-width scalars are cheap here.
      write_regs(16'd5, 16'd0, 16'd0, 16'd0);
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (10) send_word(16'($urandom), 16'($urandom), 16'($urandom));
      drain();
      write_regs(16'd0, 16'd9, 16'd4, 16'd1);
      send_word(16'd0, 16'd0, 16'hFFFF);
      repeat (10) send_word(16'($urandom), 16'($urandom), 16'($urandom));
      drain();

      // Moderate prime with ordinary random coefficients.
      write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'd251);
      random_words(30, 251);
      drain();

      repeat (50) @(negedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
